### design/lidar_point_to_pixel_projection_top_assert.svh
// Assertion macros shared by the checker of the projection block.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef LIDAR_POINT_TO_PIXEL_PROJECTION_TOP_ASSERT_SVH
`define LIDAR_POINT_TO_PIXEL_PROJECTION_TOP_ASSERT_SVH

// Checked only while out of reset
`define LPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define LPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/lpp_pkg.sv
// Shared constants, codes and types of the lidar point projection block.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpp_pkg;

  localparam int unsigned COEF_COUNT          = 12;
  localparam int unsigned COORD_FRAC_BITS_DEF = 16;
  localparam int unsigned COEF_FRAC_BITS      = 24;
  localparam int unsigned PIX_FRAC_BITS       = 16;

  // camera coordinates stay below 2^41 in magnitude
  localparam int unsigned CAM_W   = 42;
  localparam int unsigned HI_W    = CAM_W - 32;
  localparam int unsigned NUM_W   = 32 + CAM_W;
  localparam int unsigned QUO_W   = 40;
  localparam int unsigned SUM_W   = 44;
  localparam int unsigned PIX_W   = 13;
  localparam int unsigned DEP_W   = 31;
  localparam int unsigned DIM_W   = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [DIM_W-1:0] MAX_DIM = 14'd8192;

  localparam logic [31:0] FOCAL_X_RST  = 32'd47110947;
  localparam logic [31:0] FOCAL_Y_RST  = 32'd47110947;
  localparam logic [31:0] CENTER_X_RST = 32'd39792987;
  localparam logic [31:0] CENTER_Y_RST = 32'd12138296;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1280;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd720;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_SELECT    = 3'd0,
    CFG_AXIS_THRESHOLD = 3'd1,
    CFG_FOCAL_X        = 3'd2,
    CFG_FOCAL_Y        = 3'd3,
    CFG_CENTER_X       = 3'd4,
    CFG_CENTER_Y       = 3'd5,
    CFG_IMAGE_WIDTH    = 3'd6,
    CFG_IMAGE_HEIGHT   = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    MODE_POINT = 1'b0,
    MODE_LOAD  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // travels beside the quotients through the divider
  typedef struct packed {
    logic             neg_x;
    logic             neg_y;
    logic [DEP_W-1:0] depth;
  } lpp_side_t;

endpackage

`default_nettype wire

### design/lpp_div.sv
// Two-lane restoring divider, one quotient bit per stage, shared divisor.
// Depends on lpp_pkg for widths and the side-band struct.
`default_nettype none

module lpp_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [lpp_pkg::NUM_W-1:0] num_x_i,
  input  logic [lpp_pkg::NUM_W-1:0] num_y_i,
  input  logic [lpp_pkg::CAM_W-1:0] den_i,
  input  lpp_pkg::lpp_side_t       side_i,
  output logic                     valid_o,
  output logic [lpp_pkg::QUO_W-1:0] quo_x_o,
  output logic [lpp_pkg::QUO_W-1:0] quo_y_o,
  output logic                     rnz_x_o,
  output logic                     rnz_y_o,
  output lpp_pkg::lpp_side_t       side_o
);
  import lpp_pkg::*;

  logic [QUO_W-1:0] v_q;
  logic [CAM_W-1:0] rx_q [QUO_W];
  logic [CAM_W-1:0] ry_q [QUO_W];
  logic [CAM_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] nx_q [QUO_W];
  logic [QUO_W-1:0] ny_q [QUO_W];
  logic [QUO_W-1:0] qx_q [QUO_W];
  logic [QUO_W-1:0] qy_q [QUO_W];
  lpp_side_t        side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             v_in;
    logic [CAM_W-1:0] rx_in, ry_in, d_in;
    logic [QUO_W-1:0] nx_in, ny_in, qx_in, qy_in;
    lpp_side_t        s_in;
    logic [CAM_W:0]   tx, ty;
    logic             bx, by;

    if (k == 0) begin : g_first
      // upper numerator bits are known to be below the divisor
      assign v_in  = valid_i;
      assign rx_in = CAM_W'(num_x_i[NUM_W-1:QUO_W]);
      assign ry_in = CAM_W'(num_y_i[NUM_W-1:QUO_W]);
      assign nx_in = num_x_i[QUO_W-1:0];
      assign ny_in = num_y_i[QUO_W-1:0];
      assign qx_in = '0;
      assign qy_in = '0;
      assign d_in  = den_i;
      assign s_in  = side_i;
    end else begin : g_next
      assign v_in  = v_q[k-1];
      assign rx_in = rx_q[k-1];
      assign ry_in = ry_q[k-1];
      assign nx_in = nx_q[k-1];
      assign ny_in = ny_q[k-1];
      assign qx_in = qx_q[k-1];
      assign qy_in = qy_q[k-1];
      assign d_in  = den_q[k-1];
      assign s_in  = side_q[k-1];
    end

    assign tx = {rx_in, nx_in[QUO_W-1]};
    assign ty = {ry_in, ny_in[QUO_W-1]};
    assign bx = (tx >= {1'b0, d_in});
    assign by = (ty >= {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[k]   <= bx ? CAM_W'(tx - {1'b0, d_in}) : tx[CAM_W-1:0];
        ry_q[k]   <= by ? CAM_W'(ty - {1'b0, d_in}) : ty[CAM_W-1:0];
        nx_q[k]   <= {nx_in[QUO_W-2:0], 1'b0};
        ny_q[k]   <= {ny_in[QUO_W-2:0], 1'b0};
        qx_q[k]   <= {qx_in[QUO_W-2:0], bx};
        qy_q[k]   <= {qy_in[QUO_W-2:0], by};
        den_q[k]  <= d_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_x_o = qx_q[QUO_W-1];
  assign quo_y_o = qy_q[QUO_W-1];
  assign rnz_x_o = (rx_q[QUO_W-1] != '0);
  assign rnz_y_o = (ry_q[QUO_W-1] != '0);
  assign side_o  = side_q[QUO_W-1];

endmodule

`default_nettype wire

### design/lidar_point_to_pixel_projection_top.sv
// Lidar point to pixel projection: filter, extrinsic transform, divide, intrinsics.
// Depends on lpp_pkg and lpp_div.
//
//  port group   dir  beat contents
//  s_axis_*     in   tuser: mode; tdata: coef_index, coef_value, point_x/y/z
//  m_axis_*     out  tdata: pixel_col, pixel_row, depth
//  cfg_*        in   register index and write data, written when cfg_we_i is high
//
// One beat is taken every cycle while the output is not stalled; most of a
// result's path is the 40-stage restoring divider, one quotient bit a stage.
// Reset clears all valid bits and loads the register defaults; the
// coefficient table holds no reset value. A stalled output holds the whole
// pipeline; the input stage still fills while it is empty.
`default_nettype none

module lidar_point_to_pixel_projection_top #(
  parameter int unsigned COORD_FRAC_BITS = lpp_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lpp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lpp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // coef_index[3:0], coef_value[35:4], point_x[67:36], point_y[99:68], point_z[131:100]
  input  logic [lpp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode[0]
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_col[12:0], pixel_row[25:13], depth[56:26]
  output logic [lpp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import lpp_pkg::*;

  localparam int unsigned TRANS_SHIFT = COEF_FRAC_BITS - COORD_FRAC_BITS;

  // configuration registers
  axis_e              axis_sel_q;
  logic signed [31:0] thr_q;
  logic [31:0]        fx_q, fy_q, cxp_q, cyp_q;
  logic [DIM_W-1:0]   width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_sel_q <= AXIS_X;
      thr_q      <= '0;
      fx_q       <= FOCAL_X_RST;
      fy_q       <= FOCAL_Y_RST;
      cxp_q      <= CENTER_X_RST;
      cyp_q      <= CENTER_Y_RST;
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_AXIS_SELECT:    axis_sel_q <= axis_e'(cfg_wdata_i[1:0]);
        CFG_AXIS_THRESHOLD: thr_q      <= $signed(cfg_wdata_i);
        CFG_FOCAL_X:        fx_q       <= cfg_wdata_i;
        CFG_FOCAL_Y:        fy_q       <= cfg_wdata_i;
        CFG_CENTER_X:       cxp_q      <= cfg_wdata_i;
        CFG_CENTER_Y:       cyp_q      <= cfg_wdata_i;
        CFG_IMAGE_WIDTH:    width_q    <= cfg_wdata_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:   height_q   <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat fields
  logic               in_mode;
  logic [3:0]         in_coef_idx;
  logic signed [31:0] in_coef_val, in_px, in_py, in_pz;
  logic               accept, en;

  assign in_mode     = s_axis_tuser[0];
  assign in_coef_idx = s_axis_tdata[3:0];
  assign in_coef_val = $signed(s_axis_tdata[35:4]);
  assign in_px       = $signed(s_axis_tdata[67:36]);
  assign in_py       = $signed(s_axis_tdata[99:68]);
  assign in_pz       = $signed(s_axis_tdata[131:100]);

  logic out_v_q;
  logic v0_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en || !v0_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // extrinsic coefficient table, written by load beats
  logic signed [31:0] coef_q [COEF_COUNT];

  always_ff @(posedge clk_i) begin
    if (accept && in_mode == MODE_LOAD && in_coef_idx < 4'(COEF_COUNT)) begin
      coef_q[in_coef_idx] <= in_coef_val;
    end
  end

  // stage 0: point register
  logic signed [31:0] pt_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (s_axis_tready) begin
      v0_q <= accept && in_mode == MODE_POINT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q[0] <= in_px;
      pt_q[1] <= in_py;
      pt_q[2] <= in_pz;
    end
  end

  // stage 1: axis filter, matrix products, translations captured
  logic               keep;
  logic               v1_q;
  logic signed [63:0] prod_q [3][3];
  logic signed [31:0] trans_q [3];

  always_comb begin
    case (axis_sel_q)
      AXIS_X:  keep = pt_q[0] > thr_q;
      AXIS_Y:  keep = pt_q[1] > thr_q;
      AXIS_Z:  keep = pt_q[2] > thr_q;
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[r][j] <= coef_q[r*4+j] * pt_q[j];
        end
        trans_q[r] <= coef_q[r*4+3] >>> TRANS_SHIFT;
      end
    end
  end

  // stage 2: camera coordinates
  logic                    v2_q;
  logic signed [CAM_W-1:0] cam_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        cam_q[r] <= CAM_W'(prod_q[r][0] >>> COEF_FRAC_BITS)
                  + CAM_W'(prod_q[r][1] >>> COEF_FRAC_BITS)
                  + CAM_W'(prod_q[r][2] >>> COEF_FRAC_BITS)
                  + CAM_W'(trans_q[r]);
      end
    end
  end

  // stage 3: depth check, magnitudes and signs
  logic             v3_q;
  logic [CAM_W-1:0] absx_q, absy_q, den3_q;
  lpp_side_t        side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q && (cam_q[2] > 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      absx_q        <= cam_q[0][CAM_W-1] ? CAM_W'(-cam_q[0]) : cam_q[0];
      absy_q        <= cam_q[1][CAM_W-1] ? CAM_W'(-cam_q[1]) : cam_q[1];
      den3_q        <= cam_q[2];
      side3_q.neg_x <= cam_q[0][CAM_W-1];
      side3_q.neg_y <= cam_q[1][CAM_W-1];
      // saturate depth to 31 bits
      side3_q.depth <= (cam_q[2] > CAM_W'(32'h7FFF_FFFF)) ? {DEP_W{1'b1}}
                                                           : cam_q[2][DEP_W-1:0];
    end
  end

  // stage 4: focal products in two partial products each
  logic              v4_q;
  logic [63:0]       mlx_q, mly_q;
  logic [HI_W+31:0]  mhx_q, mhy_q;
  logic [CAM_W-1:0]  den4_q;
  lpp_side_t         side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mlx_q   <= fx_q * absx_q[31:0];
      mly_q   <= fy_q * absy_q[31:0];
      mhx_q   <= fx_q * absx_q[CAM_W-1:32];
      mhy_q   <= fy_q * absy_q[CAM_W-1:32];
      den4_q  <= den3_q;
      side4_q <= side3_q;
    end
  end

  // stage 5: combine partial products
  logic             v5_q;
  logic [NUM_W-1:0] numx_q, numy_q;
  logic [CAM_W-1:0] den5_q;
  lpp_side_t        side5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx_q  <= NUM_W'(mlx_q) + {mhx_q, 32'b0};
      numy_q  <= NUM_W'(mly_q) + {mhy_q, 32'b0};
      den5_q  <= den4_q;
      side5_q <= side4_q;
    end
  end

  // stage 6: drop points whose quotient reaches 2^40
  logic             v6_q;
  logic [NUM_W-1:0] numx6_q, numy6_q;
  logic [CAM_W-1:0] den6_q;
  lpp_side_t        side6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q && (CAM_W'(numx_q[NUM_W-1:QUO_W]) < den5_q)
                   && (CAM_W'(numy_q[NUM_W-1:QUO_W]) < den5_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx6_q <= numx_q;
      numy6_q <= numy_q;
      den6_q  <= den5_q;
      side6_q <= side5_q;
    end
  end

  logic             vd;
  logic [QUO_W-1:0] qx, qy;
  logic             rnzx, rnzy;
  lpp_side_t        sided;

  lpp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .num_x_i (numx6_q),
    .num_y_i (numy6_q),
    .den_i   (den6_q),
    .side_i  (side6_q),
    .valid_o (vd),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .rnz_x_o (rnzx),
    .rnz_y_o (rnzy),
    .side_o  (sided)
  );

  // stage 7: floor of signed quotient plus centre and half pixel
  logic             v7_q;
  logic [SUM_W-1:0] sumx_q, sumy_q;
  logic [DEP_W-1:0] dep7_q;
  logic [SUM_W-1:0] qxe, qye, half;

  assign qxe  = SUM_W'(qx);
  assign qye  = SUM_W'(qy);
  assign half = SUM_W'(1) << (PIX_FRAC_BITS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= vd;
    end
  end

  // negative: ~q is -q-1, add one back when the division was exact
  always_ff @(posedge clk_i) begin
    if (en) begin
      sumx_q <= (sided.neg_x ? ~qxe : qxe) + SUM_W'(cxp_q) + half
              + SUM_W'(sided.neg_x && !rnzx);
      sumy_q <= (sided.neg_y ? ~qye : qye) + SUM_W'(cyp_q) + half
              + SUM_W'(sided.neg_y && !rnzy);
      dep7_q <= sided.depth;
    end
  end

  // output register: bounds test
  localparam int unsigned PIXF_W = SUM_W - PIX_FRAC_BITS;

  logic [PIXF_W-1:0] pixx, pixy;
  logic [DIM_W-1:0]  bnd_w, bnd_h;
  logic              inx, iny;
  logic [PIX_W-1:0]  col_q, row_q;
  logic [DEP_W-1:0]  dep_q;

  assign pixx  = sumx_q[SUM_W-1:PIX_FRAC_BITS];
  assign pixy  = sumy_q[SUM_W-1:PIX_FRAC_BITS];
  assign bnd_w = (width_q > MAX_DIM) ? MAX_DIM : width_q;
  assign bnd_h = (height_q > MAX_DIM) ? MAX_DIM : height_q;
  assign inx   = !sumx_q[SUM_W-1] && (pixx < PIXF_W'(bnd_w));
  assign iny   = !sumy_q[SUM_W-1] && (pixy < PIXF_W'(bnd_h));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v7_q && inx && iny;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col_q <= pixx[PIX_W-1:0];
      row_q <= pixy[PIX_W-1:0];
      dep_q <= dep7_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_DATA_W'({dep_q, row_q, col_q});

endmodule

`default_nettype wire

### design/lpp_checker.sv
// Port-level checks on the projection block, bound to its top level.
// Depends on lpp_pkg and the assertion macro header.
`default_nettype none

`include "lidar_point_to_pixel_projection_top_assert.svh"

module lpp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lpp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import lpp_pkg::*;

  logic out_stall;

  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // a stalled result beat holds
  `LPP_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "beat moved")

  // a ready sink never holds back the source side
  `LPP_ASSERT_ALWAYS(a_ready_flow, m_axis_tready |-> s_axis_tready, "input held back")

  // kept points lie in front of the camera
  `LPP_ASSERT(a_depth_pos, m_axis_tvalid |-> m_axis_tdata[PIX_W*2 +: DEP_W] != '0, "zero depth")

  // nothing leaves while in reset
  `LPP_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "result beat during reset")

endmodule

bind lidar_point_to_pixel_projection_top lpp_checker u_lpp_checker (.*);

`default_nettype wire

### test/tb_lidar_point_to_pixel_projection_top.sv
// Self-checking bench for lidar_point_to_pixel_projection_top: drives point and
// coefficient beats, predicts every pixel and compares it field by field.
// Depends on lpp_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_lidar_point_to_pixel_projection_top;
  import lpp_pkg::*;

  localparam int   WATCHDOG_LIMIT = 3000;
  localparam int   DRAIN_CYCLES   = 80;
  localparam int   ONE_Q24        = 1 << 24;
  localparam int   ONE_Q16        = 1 << 16;

  typedef struct {
    bit [PIX_W-1:0] col;
    bit [PIX_W-1:0] row;
    bit [DEP_W-1:0] dep;
  } pixel_t;

  class projection_scoreboard;
    bit [1:0]       axis_sel;
    int             threshold;
    bit [31:0]      focal_x, focal_y, center_x, center_y;
    bit [DIM_W-1:0] width, height;
    int             extrinsic[COEF_COUNT];
    pixel_t         pending_pixels[$];
    int             errors;

    function new();
      axis_sel  = AXIS_X;
      threshold = 0;
      focal_x   = FOCAL_X_RST;
      focal_y   = FOCAL_Y_RST;
      center_x  = CENTER_X_RST;
      center_y  = CENTER_Y_RST;
      width     = WIDTH_RST;
      height    = HEIGHT_RST;
      errors    = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, bit [31:0] val);
      case (idx)
        CFG_AXIS_SELECT:    axis_sel  = val[1:0];
        CFG_AXIS_THRESHOLD: threshold = val;
        CFG_FOCAL_X:        focal_x   = val;
        CFG_FOCAL_Y:        focal_y   = val;
        CFG_CENTER_X:       center_x  = val;
        CFG_CENTER_Y:       center_y  = val;
        CFG_IMAGE_WIDTH:    width     = val[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:   height    = val[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function longint camera_axis(int row, int pt[3]);
      longint sum;
      sum = longint'(extrinsic[row*4+3]) >>> (COEF_FRAC_BITS - COORD_FRAC_BITS_DEF);
      for (int j = 0; j < 3; j++)
        sum += (longint'(extrinsic[row*4+j]) * longint'(pt[j])) >>> COEF_FRAC_BITS;
      return sum;
    endfunction

    // floor(f*c/z) offset by the principal point, rounded; 0 when off the image or when the quotient reaches 2^40
    function bit project(bit [31:0] f, longint c, longint z, bit [31:0] ctr,
                         bit [DIM_W-1:0] dim, output bit [PIX_W-1:0] pix);
      logic [127:0] mag, prod, quo, rem, dv;
      longint       t, p, bound, ac;
      bound = (dim > 8192) ? 8192 : dim;
      ac    = (c < 0) ? -c : c;
      mag   = ac;
      dv    = z;
      prod  = {96'b0, f} * mag;
      quo   = prod / dv;
      rem   = prod % dv;
      pix   = '0;
      if (quo >= (128'd1 << 40)) return 0;
      t = (c < 0) ? -longint'(quo[63:0]) - ((rem != 0) ? 1 : 0) : longint'(quo[63:0]);
      p = (t + longint'({32'b0, ctr}) + 32768) >>> PIX_FRAC_BITS;
      if (p < 0 || p >= bound) return 0;
      pix = p[PIX_W-1:0];
      return 1;
    endfunction

    function void note_beat(mode_e mode, bit [3:0] idx, int coef, int pt[3]);
      longint cx, cy, cz;
      pixel_t px;
      if (mode == MODE_LOAD) begin
        if (idx < COEF_COUNT) extrinsic[idx] = coef;
        return;
      end
      if (axis_sel > 2) return;
      if (!(pt[axis_sel] > threshold)) return;
      cx = camera_axis(0, pt);
      cy = camera_axis(1, pt);
      cz = camera_axis(2, pt);
      if (cz <= 0) return;
      if (!project(focal_x, cx, cz, center_x, width, px.col)) return;
      if (!project(focal_y, cy, cz, center_y, height, px.row)) return;
      px.dep = (cz > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : cz[DEP_W-1:0];
      pending_pixels.insert(pending_pixels.size(), px);
    endfunction

    function void check_pixel(bit [PIX_W-1:0] col, bit [PIX_W-1:0] row, bit [DEP_W-1:0] dep);
      pixel_t exp_px;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel col=%0d row=%0d depth=%0d", col, row, dep);
        errors++;
        return;
      end
      exp_px = pending_pixels.pop_front();
      if (col != exp_px.col) begin
        $error("pixel_col expected %0d actual %0d", exp_px.col, col);
        errors++;
      end
      if (row != exp_px.row) begin
        $error("pixel_row expected %0d actual %0d", exp_px.row, row);
        errors++;
      end
      if (dep != exp_px.dep) begin
        $error("depth expected %0d actual %0d", exp_px.dep, dep);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  projection_scoreboard sb = new();
  int  idle_cycles = 0;
  int  stall_left  = 0;
  bit  calm        = 0;

  lidar_point_to_pixel_projection_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // input and output beat monitors
  always @(posedge clk_i) begin
    int pt[3];
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pt[0] = s_axis_tdata[67:36];
      pt[1] = s_axis_tdata[99:68];
      pt[2] = s_axis_tdata[131:100];
      sb.note_beat(mode_e'(s_axis_tuser[0]), s_axis_tdata[3:0], s_axis_tdata[35:4], pt);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_pixel(m_axis_tdata[12:0], m_axis_tdata[25:13], m_axis_tdata[56:26]);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_lidar_point_to_pixel_projection_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver back-pressure: short stalls, the odd long one, calm stretches
  always @(negedge clk_i) begin
    int r;
    r = $urandom_range(0, 999);
    if (r < 3) calm = ~calm;
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm) begin
        if (r < 150) stall_left = $urandom_range(1, 3);
        else if (r < 160) stall_left = $urandom_range(15, 60);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(mode_e mode, bit [3:0] idx, int coef, int px, int py, int pz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0, pz, py, px, coef, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_point(int px, int py, int pz);
    send_beat(MODE_POINT, 4'($urandom_range(0, 15)), $urandom, px, py, pz);
  endtask

  task automatic send_load(bit [3:0] idx, int coef);
    send_beat(MODE_LOAD, idx, coef, $urandom, $urandom, $urandom);
  endtask

  // drain every pending pixel, then let dropped beats clear the pipeline
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, bit [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // camera looks along lidar x: cam_x = -y, cam_y = -z, cam_z = x
  function automatic int nominal_coef(int i);
    case (i)
      1, 6:    return -ONE_Q24;
      8:       return ONE_Q24;
      default: return 0;
    endcase
  endfunction

  task automatic load_nominal();
    for (int i = 0; i < COEF_COUNT; i++) send_load(4'(i), nominal_coef(i));
  endtask

  task automatic apply_phase(int ph);
    case (ph)
      1: begin
        write_reg(CFG_AXIS_SELECT, AXIS_X);
        write_reg(CFG_AXIS_THRESHOLD, 0);
        write_reg(CFG_FOCAL_X, FOCAL_X_RST);
        write_reg(CFG_FOCAL_Y, FOCAL_Y_RST);
        write_reg(CFG_CENTER_X, CENTER_X_RST);
        write_reg(CFG_CENTER_Y, CENTER_Y_RST);
        write_reg(CFG_IMAGE_WIDTH, WIDTH_RST);
        write_reg(CFG_IMAGE_HEIGHT, HEIGHT_RST);
      end
      2: begin
        write_reg(CFG_AXIS_SELECT, AXIS_Y);
        write_reg(CFG_AXIS_THRESHOLD, 32'h8000_0000);
      end
      3: begin
        write_reg(CFG_AXIS_SELECT, AXIS_Z);
        write_reg(CFG_AXIS_THRESHOLD, -ONE_Q16);
      end
      4: write_reg(CFG_AXIS_SELECT, 2'd3);
      5: begin
        write_reg(CFG_AXIS_SELECT, AXIS_X);
        write_reg(CFG_AXIS_THRESHOLD, 32'h7FFF_FFFF);
      end
      6: begin
        write_reg(CFG_AXIS_THRESHOLD, 32'h8000_0000);
        write_reg(CFG_FOCAL_X, 0);
        write_reg(CFG_FOCAL_Y, 0);
        write_reg(CFG_CENTER_X, 32'h0064_8000);
        write_reg(CFG_CENTER_Y, 32'h0000_7FFF);
        write_reg(CFG_IMAGE_WIDTH, 8192);
        write_reg(CFG_IMAGE_HEIGHT, 8192);
      end
      7: begin
        write_reg(CFG_FOCAL_X, 32'hFFFF_FFFF);
        write_reg(CFG_FOCAL_Y, 32'hFFFF_FFFF);
        write_reg(CFG_CENTER_X, 32'hFFFF_FFFF);
        write_reg(CFG_CENTER_Y, 0);
      end
      8: begin
        write_reg(CFG_FOCAL_X, 32'h0010_0000);
        write_reg(CFG_FOCAL_Y, 32'h0010_0000);
        write_reg(CFG_CENTER_X, 32'h0000_6000);
        write_reg(CFG_CENTER_Y, 32'h0000_6000);
        write_reg(CFG_IMAGE_WIDTH, 1);
        write_reg(CFG_IMAGE_HEIGHT, 1);
      end
      9: begin
        write_reg(CFG_FOCAL_X, FOCAL_X_RST);
        write_reg(CFG_FOCAL_Y, FOCAL_Y_RST);
        write_reg(CFG_CENTER_X, CENTER_X_RST);
        write_reg(CFG_CENTER_Y, CENTER_Y_RST);
        write_reg(CFG_IMAGE_WIDTH, 14'h3FFF);
        write_reg(CFG_IMAGE_HEIGHT, 0);
      end
      default: begin
        write_reg(CFG_AXIS_SELECT, $urandom_range(AXIS_X, AXIS_Z));
        write_reg(CFG_AXIS_THRESHOLD, $urandom_range(0, 20 * ONE_Q16) - 10 * ONE_Q16);
        write_reg(CFG_FOCAL_X, $urandom_range(200, 1500) * ONE_Q16 + $urandom_range(0, 65535));
        write_reg(CFG_FOCAL_Y, $urandom_range(200, 1500) * ONE_Q16 + $urandom_range(0, 65535));
        write_reg(CFG_IMAGE_WIDTH, $urandom_range(64, 8192));
        write_reg(CFG_IMAGE_HEIGHT, $urandom_range(64, 8192));
        write_reg(CFG_CENTER_X, $urandom_range(0, sb.width) * ONE_Q16 + $urandom_range(0, 65535));
        write_reg(CFG_CENTER_Y, $urandom_range(0, sb.height) * ONE_Q16 + $urandom_range(0, 65535));
      end
    endcase
  endtask

  task automatic random_beat();
    int r, dist_x, px, py, pz;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // loads: mostly small tilts of the nominal matrix, sometimes anything
      if ($urandom_range(0, 2) == 0) send_load(4'($urandom_range(0, 15)), $urandom);
      else begin
        px = $urandom_range(0, 15);
        send_load(4'(px), ((px < COEF_COUNT) ? nominal_coef(px) : 0)
                          + $urandom_range(0, 1 << 21) - (1 << 20));
      end
    end else if (r < 20) begin
      send_point($urandom, $urandom, $urandom);
    end else begin
      dist_x = $urandom_range(1, 60);
      px = ($urandom_range(0, 9) == 0 ? -dist_x : dist_x) * ONE_Q16 + $urandom_range(0, 65535);
      py = $urandom_range(0, 2 * dist_x * 52429) - dist_x * 52429;
      pz = $urandom_range(0, dist_x * 32768) - dist_x * 16384;
      send_point(px, py, pz);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_AXIS_SELECT;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_POINT;
    m_axis_tready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: table fill, ignored loads, field extremes, drops
    load_nominal();
    send_load(4'd12, 32'h7FFF_FFFF);
    send_load(4'd15, 32'h8000_0000);
    send_point(10 * ONE_Q16, 0, 0);
    send_point(5 * ONE_Q16, ONE_Q16, -ONE_Q16 / 2);
    send_point(-10 * ONE_Q16, 0, 0);
    send_point(0, 0, 0);
    send_point(1, 0, 0);
    send_point(1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 0, 0);
    send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(2 * ONE_Q16, -2 * ONE_Q16, 0);
    wait_idle();

    for (int ph = 1; ph <= 12; ph++) begin
      apply_phase(ph);
      load_nominal();
      repeat (ph == 4 || ph == 5 ? 60 : 140) random_beat();
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending_pixels.size() == 0)
      $display("tb_lidar_point_to_pixel_projection_top: clean");
    else
      $display("tb_lidar_point_to_pixel_projection_top: errors");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/lpp_pkg.sv
design/lpp_div.sv
design/lidar_point_to_pixel_projection_top.sv
design/lpp_checker.sv
test/tb_lidar_point_to_pixel_projection_top.sv
